// ----- hw/rtl/spc_pkg.sv -----
package spc_pkg;

   // Square root result width and quotient bits of the normal divider
   localparam int SqrtBits = 34;
   localparam int DivBits  = 33;
   // Input register, two square stages, gap stage, normal, multiply, round
   localparam int Latency  = 7 + SqrtBits + DivBits;

   localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

   typedef struct packed {
      logic [15:0]        first_index;
      logic [15:0]        second_index;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic [30:0]        first_radius;
      logic [30:0]        second_radius;
   } req_type;

   typedef struct packed {
      logic [15:0]        body_a;
      logic [15:0]        body_b;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
   } rsp_type;

   // Data that rides along the square root pipeline
   typedef struct packed {
      logic [15:0]        body_a;
      logic [15:0]        body_b;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic signed [32:0] sx;
      logic signed [32:0] sy;
      logic signed [32:0] sz;
      logic [31:0]        rsum;
      logic signed [31:0] rdiff;
   } sqrt_side_type;

   // Data that rides along the divider pipeline
   typedef struct packed {
      logic [15:0]        body_a;
      logic [15:0]        body_b;
      logic [2:0]         neg;
      logic signed [32:0] sx;
      logic signed [32:0] sy;
      logic signed [32:0] sz;
      logic signed [31:0] rdiff;
      logic               zero_len;
   } div_side_type;

endpackage

// ----- hw/rtl/sphere_pair_contact.sv -----
// Sphere pair contact test.
// Request channel: drive req_data and raise start; the request is taken at
// any edge where start is high and busy is low. busy stays low, so one pair
// may be issued every cycle.
// Result channel: a contact appears on rsp_data with rsp_valid high for
// exactly one cycle, once its request has passed every stage. Pairs whose gap
// is positive produce no result; results keep request order.
// Latency is set by the 34 stage square root (one root bit per stage) and the
// 33 stage normal divider (one quotient bit per stage, three lanes), plus
// input, square, sum, gap, normal, multiply and rounding stages.
// Throughput: one pair per cycle.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// Reset (synchronous) clears all valid bits, dropping any pairs in flight.
module sphere_pair_contact
   import spc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   assign busy = 1'b0;

   // Input stage: differences, sums and radius terms
   logic          a_valid_ff;
   sqrt_side_type a_side_ff;
   sqrt_side_type a_side_in;

   always_comb begin
      a_side_in.body_a = req_data.first_index;
      a_side_in.body_b = req_data.second_index;
      a_side_in.dx = 33'(req_data.first_x) - 33'(req_data.second_x);
      a_side_in.dy = 33'(req_data.first_y) - 33'(req_data.second_y);
      a_side_in.dz = 33'(req_data.first_z) - 33'(req_data.second_z);
      a_side_in.sx = 33'(req_data.first_x) + 33'(req_data.second_x);
      a_side_in.sy = 33'(req_data.first_y) + 33'(req_data.second_y);
      a_side_in.sz = 33'(req_data.first_z) + 33'(req_data.second_z);
      a_side_in.rsum = {1'b0, req_data.first_radius} + {1'b0, req_data.second_radius};
      a_side_in.rdiff = $signed({1'b0, req_data.second_radius})
                      - $signed({1'b0, req_data.first_radius});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_side_ff <= a_side_in;
   end

   // Square stage: magnitude of 2^32 squares to 2^64 exactly, else 32x32
   logic          b_valid_ff;
   sqrt_side_type b_side_ff;
   logic [63:0]   b_sq_ff [0:2];
   logic [2:0]    b_top_ff;
   logic [32:0]   a_mag [0:2];

   assign a_mag[0] = a_side_ff.dx[32] ? 33'(-a_side_ff.dx) : 33'(a_side_ff.dx);
   assign a_mag[1] = a_side_ff.dy[32] ? 33'(-a_side_ff.dy) : 33'(a_side_ff.dy);
   assign a_mag[2] = a_side_ff.dz[32] ? 33'(-a_side_ff.dz) : 33'(a_side_ff.dz);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_side_ff <= a_side_ff;
      for (int i = 0; i < 3; i++) begin
         b_sq_ff[i]  <= a_mag[i][31:0] * a_mag[i][31:0];
         b_top_ff[i] <= a_mag[i][32];
      end
   end

   // Sum of squares
   logic          c_valid_ff;
   sqrt_side_type c_side_ff;
   logic [65:0]   c_sum_ff;
   logic [64:0]   b_full [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_full[i] = b_top_ff[i] ? {1'b1, 64'd0} : {1'b0, b_sq_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_side_ff <= b_side_ff;
      c_sum_ff  <= {1'b0, b_full[0]} + {1'b0, b_full[1]} + {1'b0, b_full[2]};
   end

   // Center distance
   logic          s_valid;
   logic [33:0]   s_root;
   sqrt_side_type s_side;

   spc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .radicand  (c_sum_ff),
      .in_side   (c_side_ff),
      .out_valid (s_valid),
      .root      (s_root),
      .out_side  (s_side)
   );

   // Gap stage: drop separated pairs, set up the normal division
   logic          d_valid_ff;
   logic [62:0]   d_num_ff [0:2];
   logic [33:0]   d_den_ff;
   div_side_type  d_side_ff;
   div_side_type  d_side_in;
   logic          s_hit;
   logic [32:0]   s_mag [0:2];

   assign s_hit = {1'b0, s_root} <= {3'd0, s_side.rsum};
   assign s_mag[0] = s_side.dx[32] ? 33'(-s_side.dx) : 33'(s_side.dx);
   assign s_mag[1] = s_side.dy[32] ? 33'(-s_side.dy) : 33'(s_side.dy);
   assign s_mag[2] = s_side.dz[32] ? 33'(-s_side.dz) : 33'(s_side.dz);

   always_comb begin
      d_side_in.body_a   = s_side.body_a;
      d_side_in.body_b   = s_side.body_b;
      // Normal is -d / L: negative where d is positive
      d_side_in.neg[0]   = !s_side.dx[32] && (s_side.dx != '0);
      d_side_in.neg[1]   = !s_side.dy[32] && (s_side.dy != '0);
      d_side_in.neg[2]   = !s_side.dz[32] && (s_side.dz != '0);
      d_side_in.sx       = s_side.sx;
      d_side_in.sy       = s_side.sy;
      d_side_in.sz       = s_side.sz;
      d_side_in.rdiff    = s_side.rdiff;
      d_side_in.zero_len = (s_root == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= s_valid && s_hit;
      end
      d_side_ff <= d_side_in;
      d_den_ff  <= s_root;
      for (int i = 0; i < 3; i++) begin
         d_num_ff[i] <= {s_mag[i], 30'd0};
      end
   end

   // Normal division
   logic          q_valid;
   logic [32:0]   q_val [0:2];
   div_side_type  q_side;

   spc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .num_x     (d_num_ff[0]),
      .num_y     (d_num_ff[1]),
      .num_z     (d_num_ff[2]),
      .den       (d_den_ff),
      .in_side   (d_side_ff),
      .out_valid (q_valid),
      .quot_x    (q_val[0]),
      .quot_y    (q_val[1]),
      .quot_z    (q_val[2]),
      .out_side  (q_side)
   );

   // Normal stage: saturate, sign, coincident-center default
   logic               e_valid_ff;
   div_side_type       e_side_ff;
   logic signed [31:0] e_n_ff [0:2];
   logic signed [31:0] e_n_in [0:2];
   logic [31:0]        q_sat  [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_sat[i]  = (q_val[i] > 33'(OneQ30)) ? OneQ30 : q_val[i][31:0];
         e_n_in[i] = q_side.neg[i] ? $signed(-q_sat[i]) : $signed(q_sat[i]);
      end
      if (q_side.zero_len) begin
         e_n_in[0] = -OneQ30;
         e_n_in[1] = '0;
         e_n_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= q_valid;
      end
      e_side_ff <= q_side;
      for (int i = 0; i < 3; i++) begin
         e_n_ff[i] <= e_n_in[i];
      end
   end

   // Multiply stage: radius difference times normal
   logic               f_valid_ff;
   div_side_type       f_side_ff;
   logic signed [31:0] f_n_ff    [0:2];
   logic signed [63:0] f_prod_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_side_ff <= e_side_ff;
      for (int i = 0; i < 3; i++) begin
         f_n_ff[i]    <= e_n_ff[i];
         f_prod_ff[i] <= 64'(e_side_ff.rdiff) * 64'(e_n_ff[i]);
      end
   end

   // Round stage: half up, then clamp to 32 bits
   logic               g_valid_ff;
   rsp_type            g_rsp_ff;
   rsp_type            g_rsp_in;
   logic signed [32:0] f_sum  [0:2];
   logic signed [65:0] f_v    [0:2];
   logic signed [34:0] f_q    [0:2];
   logic signed [31:0] f_pt   [0:2];

   assign f_sum[0] = f_side_ff.sx;
   assign f_sum[1] = f_side_ff.sy;
   assign f_sum[2] = f_side_ff.sz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_v[i] = $signed({{3{f_sum[i][32]}}, f_sum[i], 30'd0})
                + 66'(f_prod_ff[i]) + $signed(66'h4000_0000);
         f_q[i] = f_v[i][65:31];
         if (f_q[i] > 35'sh0_7FFF_FFFF) begin
            f_pt[i] = 32'sh7FFF_FFFF;
         end else if (f_q[i] < -35'sh0_8000_0000) begin
            f_pt[i] = 32'sh8000_0000;
         end else begin
            f_pt[i] = f_q[i][31:0];
         end
      end
      g_rsp_in.body_a   = f_side_ff.body_a;
      g_rsp_in.body_b   = f_side_ff.body_b;
      g_rsp_in.point_x  = f_pt[0];
      g_rsp_in.point_y  = f_pt[1];
      g_rsp_in.point_z  = f_pt[2];
      g_rsp_in.normal_x = f_n_ff[0];
      g_rsp_in.normal_y = f_n_ff[1];
      g_rsp_in.normal_z = f_n_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
      g_rsp_ff <= g_rsp_in;
   end

   assign rsp_valid = g_valid_ff;
   assign rsp_data  = g_rsp_ff;

   // A result always traces back to a request taken a full latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without matching request");

   // Normal components stay within the unit range
   a_normal_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.normal_x <= OneQ30) && (rsp_data.normal_x >= -OneQ30)
                 && (rsp_data.normal_y <= OneQ30) && (rsp_data.normal_y >= -OneQ30)
                 && (rsp_data.normal_z <= OneQ30) && (rsp_data.normal_z >= -OneQ30))
      else $error("normal component out of range");

   // A divider entry is only made from a valid square root result
   a_gap_drop : assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> $past(s_valid))
      else $error("divider entry without square root result");

endmodule

// ----- hw/rtl/spc_sqrt.sv -----
module spc_sqrt
   import spc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [65:0]   radicand,
   input  sqrt_side_type in_side,
   output logic          out_valid,
   output logic [33:0]   root,
   output sqrt_side_type out_side
);

   logic                valid_ff [1:SqrtBits];
   logic [33:0]         root_ff  [1:SqrtBits];
   logic [65:0]         rem_ff   [1:SqrtBits];
   sqrt_side_type       side_ff  [1:SqrtBits];

   logic                valid_src [0:SqrtBits-1];
   logic [33:0]         root_src  [0:SqrtBits-1];
   logic [65:0]         rem_src   [0:SqrtBits-1];
   sqrt_side_type       side_src  [0:SqrtBits-1];

   assign valid_src[0] = in_valid;
   assign root_src[0]  = '0;
   assign rem_src[0]   = radicand;
   assign side_src[0]  = in_side;

   genvar k;
   generate
      for (k = 0; k < SqrtBits; k++) begin : g_stage
         localparam int B = SqrtBits - 1 - k;
         logic [67:0] trial;
         logic        take;

         if (k > 0) begin : g_link
            assign valid_src[k] = valid_ff[k];
            assign root_src[k]  = root_ff[k];
            assign rem_src[k]   = rem_ff[k];
            assign side_src[k]  = side_ff[k];
         end

         // Try this root bit: (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
         assign trial = ({34'd0, root_src[k]} << (B + 1)) | (68'd1 << (2 * B));
         assign take  = {2'b00, rem_src[k]} >= trial;

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k+1] <= 1'b0;
            end else begin
               valid_ff[k+1] <= valid_src[k];
            end
            side_ff[k+1] <= side_src[k];
            if (take) begin
               root_ff[k+1] <= root_src[k] | (34'd1 << B);
               rem_ff[k+1]  <= rem_src[k] - trial[65:0];
            end else begin
               root_ff[k+1] <= root_src[k];
               rem_ff[k+1]  <= rem_src[k];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[SqrtBits];
   assign root      = root_ff[SqrtBits];
   assign out_side  = side_ff[SqrtBits];

endmodule

// ----- hw/rtl/spc_div.sv -----
module spc_div
   import spc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [62:0]  num_x,
   input  logic [62:0]  num_y,
   input  logic [62:0]  num_z,
   input  logic [33:0]  den,
   input  div_side_type in_side,
   output logic         out_valid,
   output logic [32:0]  quot_x,
   output logic [32:0]  quot_y,
   output logic [32:0]  quot_z,
   output div_side_type out_side
);

   logic          valid_ff [1:DivBits];
   logic [33:0]   den_ff   [1:DivBits];
   logic [62:0]   rem_ff   [1:DivBits][0:2];
   logic [32:0]   quot_ff  [1:DivBits][0:2];
   div_side_type  side_ff  [1:DivBits];

   logic          valid_src [0:DivBits-1];
   logic [33:0]   den_src   [0:DivBits-1];
   logic [62:0]   rem_src   [0:DivBits-1][0:2];
   logic [32:0]   quot_src  [0:DivBits-1][0:2];
   div_side_type  side_src  [0:DivBits-1];

   assign valid_src[0]   = in_valid;
   assign den_src[0]     = den;
   assign rem_src[0][0]  = num_x;
   assign rem_src[0][1]  = num_y;
   assign rem_src[0][2]  = num_z;
   assign quot_src[0][0] = '0;
   assign quot_src[0][1] = '0;
   assign quot_src[0][2] = '0;
   assign side_src[0]    = in_side;

   genvar k, a;
   generate
      for (k = 0; k < DivBits; k++) begin : g_stage
         localparam int B = DivBits - 1 - k;
         logic [66:0] shifted;

         if (k > 0) begin : g_link
            assign valid_src[k] = valid_ff[k];
            assign den_src[k]   = den_ff[k];
            assign side_src[k]  = side_ff[k];
            for (a = 0; a < 3; a++) begin : g_axis_link
               assign rem_src[k][a]  = rem_ff[k][a];
               assign quot_src[k][a] = quot_ff[k][a];
            end
         end

         assign shifted = {33'd0, den_src[k]} << B;

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k+1] <= 1'b0;
            end else begin
               valid_ff[k+1] <= valid_src[k];
            end
            den_ff[k+1]  <= den_src[k];
            side_ff[k+1] <= side_src[k];
         end

         // Subtract the shifted divisor where it fits, one quotient bit per lane
         for (a = 0; a < 3; a++) begin : g_axis
            logic take;
            assign take = {4'd0, rem_src[k][a]} >= shifted;
            always_ff @(posedge clock) begin
               if (take) begin
                  rem_ff[k+1][a]  <= rem_src[k][a] - shifted[62:0];
                  quot_ff[k+1][a] <= quot_src[k][a] | (33'd1 << B);
               end else begin
                  rem_ff[k+1][a]  <= rem_src[k][a];
                  quot_ff[k+1][a] <= quot_src[k][a];
               end
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[DivBits];
   assign quot_x    = quot_ff[DivBits][0];
   assign quot_y    = quot_ff[DivBits][1];
   assign quot_z    = quot_ff[DivBits][2];
   assign out_side  = side_ff[DivBits];

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import spc_pkg::*;

   localparam int NumRandom = 1650;
   localparam int DrainCycles = Latency + 20;
   localparam longint QOne = 64'sd1073741824;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches = 0;
   int num_requests = 0;
   int num_contacts = 0;
   int num_coincident = 0;

   sphere_pair_contact dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Floor integer square root of a 66 bit value, one bit at a time
   function automatic logic [33:0] floor_root(input logic [65:0] sq);
      logic [33:0] root;
      logic [33:0] cand;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         if ({34'd0, cand} * {34'd0, cand} <= {2'd0, sq}) root = cand;
      end
      return root;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Round half up then saturate to 32 bits
   function automatic longint point_round(input longint v);
      longint t;
      longint q;
      t = v + QOne;
      q = t >>> 31;
      return clamp(q, -64'sd2147483648, 64'sd2147483647);
   endfunction

   class contact_scoreboard;
      rsp_type pending[$];

      function void note_request(req_type r);
         longint c1[3], c2[3], d[3], n[3];
         logic [65:0] sumsq;
         logic [63:0] mag;
         longint len, rsum, rdiff;
         rsp_type e;
         c1[0] = r.first_x;  c1[1] = r.first_y;  c1[2] = r.first_z;
         c2[0] = r.second_x; c2[1] = r.second_y; c2[2] = r.second_z;
         sumsq = '0;
         for (int k = 0; k < 3; k++) begin
            d[k] = c1[k] - c2[k];
            mag = d[k] < 0 ? -d[k] : d[k];
            sumsq += {2'd0, mag * mag};
         end
         len = longint'(floor_root(sumsq));
         rsum = longint'(r.first_radius) + longint'(r.second_radius);
         rdiff = longint'(r.second_radius) - longint'(r.first_radius);
         num_requests++;
         if (len - rsum > 0) return;
         if (len == 0) begin
            n[0] = -QOne; n[1] = 0; n[2] = 0;
            num_coincident++;
         end else begin
            for (int k = 0; k < 3; k++) n[k] = clamp((-d[k] * QOne) / len, -QOne, QOne);
         end
         e.body_a = r.first_index;
         e.body_b = r.second_index;
         e.point_x = 32'(point_round((c1[0] + c2[0]) * QOne + rdiff * n[0]));
         e.point_y = 32'(point_round((c1[1] + c2[1]) * QOne + rdiff * n[1]));
         e.point_z = 32'(point_round((c1[2] + c2[2]) * QOne + rdiff * n[2]));
         e.normal_x = 32'(n[0]);
         e.normal_y = 32'(n[1]);
         e.normal_z = 32'(n[2]);
         pending = {pending, e};
      endfunction

      task check_contact(rsp_type got);
         rsp_type e;
         num_contacts++;
         if (pending.size() == 0) begin
            report_mismatch("contact with none pending", got.body_a, -1);
            return;
         end
         e = pending.pop_front();
         if (got.body_a !== e.body_a) report_mismatch("body_a", got.body_a, e.body_a);
         if (got.body_b !== e.body_b) report_mismatch("body_b", got.body_b, e.body_b);
         if (got.point_x !== e.point_x) report_mismatch("point_x", got.point_x, e.point_x);
         if (got.point_y !== e.point_y) report_mismatch("point_y", got.point_y, e.point_y);
         if (got.point_z !== e.point_z) report_mismatch("point_z", got.point_z, e.point_z);
         if (got.normal_x !== e.normal_x) report_mismatch("normal_x", got.normal_x, e.normal_x);
         if (got.normal_y !== e.normal_y) report_mismatch("normal_y", got.normal_y, e.normal_y);
         if (got.normal_z !== e.normal_z) report_mismatch("normal_z", got.normal_z, e.normal_z);
      endtask
   endclass

   contact_scoreboard contacts = new();

   // Check each contact as it is shown
   always @(posedge clock) begin
      if (!reset && rsp_valid) contacts.check_contact(rsp_data);
   end

   // Present one request and hold until taken; start stays high for a following one
   task automatic send_request(input req_type r);
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      contacts.note_request(r);
      @(negedge clock);
   endtask

   // Hold until every expected contact has come back
   task automatic drain_contacts();
      while (contacts.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(input int style);
      case (style)
         0: return $urandom();
         1: return $signed(32'($urandom_range(0, 40000))) - 32'sd20000;
         default: return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type r;
      int style;
      style = $urandom_range(0, 5);
      r.first_index = 16'($urandom());
      r.second_index = 16'($urandom());
      r.first_x = rand_coord(style % 3);
      r.first_y = rand_coord(style % 3);
      r.first_z = rand_coord(style % 3);
      // Place the second sphere near the first most of the time
      if (style >= 2) begin
         r.second_x = r.first_x + rand_coord(2);
         r.second_y = r.first_y + rand_coord(2);
         r.second_z = r.first_z + rand_coord(2);
         r.first_radius = 31'($urandom_range(0, 32'h0030_0000));
         r.second_radius = 31'($urandom_range(0, 32'h0030_0000));
         if (style == 5) begin
            r.second_x = r.first_x; r.second_y = r.first_y; r.second_z = r.first_z;
         end
      end else begin
         r.second_x = rand_coord(style % 3);
         r.second_y = rand_coord(style % 3);
         r.second_z = rand_coord(style % 3);
         r.first_radius = 31'($urandom());
         r.second_radius = 31'($urandom());
      end
      return r;
   endfunction

   function automatic req_type make_pair(input logic signed [31:0] ax, ay, az, bx, by, bz,
                                         input logic [30:0] ra, rb);
      req_type r;
      r.first_index = 16'($urandom()); r.second_index = 16'($urandom());
      r.first_x = ax; r.first_y = ay; r.first_z = az;
      r.second_x = bx; r.second_y = by; r.second_z = bz;
      r.first_radius = ra; r.second_radius = rb;
      return r;
   endfunction

   initial begin
      req_type directed[$];
      int gap;
      int burst;
      bit drained;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extremes, coincident centers, touching, and saturated points
      directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pair(5, 5, 5, 5, 5, 5, 31'h7FFFFFFF, 0)};
      directed = {directed, make_pair(0, 0, 0, 32'sh10000, 0, 0, 31'h8000, 31'h8000)};
      directed = {directed, make_pair(0, 0, 0, 32'sh10001, 0, 0, 31'h8000, 31'h8000)};
      directed = {directed, make_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      31'h7FFFFFFF, 31'h7FFFFFFF)};
      directed = {directed, make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      31'h7FFFFFFF, 31'h7FFFFFFF)};
      directed = {directed, make_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      0, 31'h7FFFFFFF)};
      directed = {directed, make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      31'h7FFFFFFF, 0)};
      directed = {directed, make_pair(0, 0, 0, 0, 0, 32'sh7FFFFFFF,
                                      31'h7FFFFFFF, 31'h7FFFFFFF)};
      directed = {directed, make_pair(0, 0, 0, 0, 32'sh80000000, 0,
                                      31'h7FFFFFFF, 31'h7FFFFFFF)};
      directed = {directed, make_pair(1, 2, 3, 1, 2, 4, 1, 0)};
      directed = {directed, make_pair(-1, -1, -1, 1, 1, 1, 2, 2)};
      directed = {directed, make_pair(100, 0, 0, -100, 0, 0, 0, 0)};
      foreach (directed[i]) begin
         directed[i].first_index = i[0] ? 16'hFFFF : 16'h0000;
         directed[i].second_index = i[0] ? 16'h0000 : 16'hFFFF;
         send_request(directed[i]);
      end
      start <= 1'b0;

      // Let the pipeline empty once before the random traffic
      drain_contacts();
      repeat (DrainCycles) @(negedge clock);

      // Random pairs in bursts with gaps; a burst with no gap runs into the next
      drained = 1'b0;
      for (int i = 0; i < NumRandom; ) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && i < NumRandom; j++, i++)
            send_request(random_pair());
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 90);
         if (gap != 0 || (!drained && i >= NumRandom / 2)) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // Pause halfway until every contact is back
         if (!drained && i >= NumRandom / 2) begin
            drained = 1'b1;
            drain_contacts();
            @(negedge clock);
         end
      end
      start <= 1'b0;

      drain_contacts();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d sphere pairs, checked %0d contacts (%0d with coincident centers).",
               num_requests, num_contacts, num_coincident);
      if (mismatches == 0 && contacts.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
